// ===== sv/lsb_pkg.sv =====
// Shared types and constants for the scan binner.
`timescale 1ns / 1ps
package lsb_pkg;

    localparam logic [7:0] SYNC1_BYTE  = 8'hA5;
    localparam logic [7:0] SYNC2_BYTE  = 8'h5A;
    localparam logic [7:0] HEADER_TYPE = 8'h81;
    localparam logic [5:0] MIN_QUALITY_RESET = 6'd10;
    localparam logic [8:0] DEGREES = 9'd360;

    // Item modes
    localparam logic MODE_BYTE  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Register byte addresses
    localparam logic [1:0] ADDR_MIN_QUALITY = 2'd0;

    typedef enum logic [1:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_HEADER,
        PH_NODES
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_COMMIT_RD,
        ST_COMMIT_WR,
        ST_PUBLISH,
        ST_QUERY,
        ST_QUERY_LAST,
        ST_DONE
    } seq_state_t;

    // Result of the byte parser toward the sequencer.
    typedef struct packed {
        logic        commit;
        logic        header_error;
        logic        check_error;
        logic        sync;
        logic [5:0]  quality;
        logic [14:0] angle_word;
        logic [15:0] distance;
    } parse_result_t;

endpackage

// ===== sv/lsb_parser.sv =====
// Byte-level stream parser: sync, header and node assembly.
`timescale 1ns / 1ps
module lsb_parser
    import lsb_pkg::*;
#(
    parameter int HEADER_BYTES = 5
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          byte_valid,
    input  logic [7:0]    data_byte,
    output parse_result_t result
);

    localparam int HPW = $clog2(HEADER_BYTES + 1);

    phase_t          phase_reg, phase_next;
    logic [HPW-1:0]  hpos_reg, hpos_next;
    logic [2:0]      npos_reg, npos_next;
    logic [7:0]      nb0_reg, nb1_reg, nb2_reg, nb3_reg;

    // Advance the parser on each stream item
    always_comb
    begin
        phase_next = phase_reg;
        hpos_next  = hpos_reg;
        npos_next  = npos_reg;
        result     = '0;
        result.sync       = nb0_reg[0];
        result.quality    = nb0_reg[7:2];
        result.angle_word = {nb2_reg, nb1_reg[7:1]};
        result.distance   = {data_byte, nb3_reg};
        if (byte_valid)
        begin
            case (phase_reg)
                PH_SYNC1:
                begin
                    if (data_byte == SYNC1_BYTE)
                        phase_next = PH_SYNC2;
                end
                PH_SYNC2:
                begin
                    if (data_byte == SYNC2_BYTE)
                    begin
                        hpos_next  = '0;
                        phase_next = PH_HEADER;
                    end
                    else if (data_byte != SYNC1_BYTE)
                        phase_next = PH_SYNC1;
                end
                PH_HEADER:
                begin
                    hpos_next = hpos_reg + 1'b1;
                    if (hpos_reg + 1'b1 >= HPW'(HEADER_BYTES))
                    begin
                        hpos_next = '0;
                        if (data_byte == HEADER_TYPE)
                        begin
                            npos_next  = '0;
                            phase_next = PH_NODES;
                        end
                        else
                        begin
                            result.header_error = 1'b1;
                            phase_next = PH_SYNC1;
                        end
                    end
                end
                default:
                begin
                    if (npos_reg >= 3'd4)
                    begin
                        npos_next = '0;
                        if (nb1_reg[0])
                            result.commit = 1'b1;
                        else
                            result.check_error = 1'b1;
                    end
                    else
                        npos_next = npos_reg + 1'b1;
                end
            endcase
        end
    end

    // Hold parser control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SYNC1;
            hpos_reg  <= '0;
            npos_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            hpos_reg  <= hpos_next;
            npos_reg  <= npos_next;
        end
    end

    // Capture node bytes
    always_ff @(posedge clk)
    begin
        if (byte_valid && phase_reg == PH_NODES)
        begin
            case (npos_reg)
                3'd0: nb0_reg <= data_byte;
                3'd1: nb1_reg <= data_byte;
                3'd2: nb2_reg <= data_byte;
                3'd3: nb3_reg <= data_byte;
                default: ;
            endcase
        end
    end

endmodule

// ===== sv/lidar_scan_binner.sv =====
// Top level of the scan binner: config port, sequencer and bucket memories.
//
// Usage: drive mode and the payload fields and pulse start while busy is low.
// mode 0 feeds one stream byte to the parser; mode 1 runs a zone query on
// the last published sweep. Every item yields exactly one result, shown
// for one cycle with result_valid; the receiver cannot stall it.
// A plain stream byte is accepted in ST_IDLE and parsed in ST_DONE, which then
// shows its result. A node commit adds a bucket read and, when the node is stored,
// a bucket write. A sweep publish walks every bucket once through the one memory
// port set. A query walks all buckets through the shared compare unit, one bucket
// a cycle. The next item is taken the cycle after a result.
// After reset the block runs a clearing pass over every bucket of the working and
// published memories; busy stays high meanwhile.
// min_quality sits at APB address 0 and resets to 10; write it only idle.
`timescale 1ns / 1ps
module lidar_scan_binner
    import lsb_pkg::*;
#(
    parameter int BUCKETS      = 360,
    parameter int HEADER_BYTES = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [7:0]  data_byte,
    input  logic [8:0]  zone_start,
    input  logic [8:0]  zone_end,
    input  logic [15:0] max_distance,
    output logic        result_valid,
    output logic        sweep_done,
    output logic        node_error,
    output logic [31:0] sweep_count,
    output logic [31:0] error_count,
    output logic        obstacle_found,
    output logic        nearest_found,
    output logic [15:0] nearest_distance
);

    localparam int AW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam logic [AW-1:0] LAST = AW'(BUCKETS - 1);
    // Reciprocal of BUCKETS scaled by 2^18, exact for degrees below 512
    localparam logic [18:0] BUCKET_RECIP = 19'((2**18 + BUCKETS - 1) / BUCKETS);

    // Memories
    logic [15:0] wdist_mem [BUCKETS];
    logic [5:0]  wqual_mem [BUCKETS];
    logic [15:0] pdist_mem [BUCKETS];

    seq_state_t    state_reg, state_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [5:0]    minq_reg;
    logic [31:0]   sweeps_reg, sweeps_next, errors_reg, errors_next;
    logic          armed_reg, armed_next;
    logic          mode_reg;
    logic [7:0]    byte_reg;
    logic [8:0]    zs_reg, ze_reg;
    logic [15:0]   lim_reg;
    logic          done_reg, done_next, err_reg, err_next;
    logic          obst_reg, obst_next, found_reg, found_next;
    logic [15:0]   near_reg, near_next;
    logic          store_reg, store_next;
    logic [AW-1:0] bucket_reg, bucket_next;
    logic [15:0]   ndist_reg, ndist_next;
    logic [5:0]    nqual_reg, nqual_next;
    logic          byte_valid;
    parse_result_t pres;

    // Memory ports
    logic          w_we, p_we;
    logic [AW-1:0] w_waddr, p_waddr;
    logic [15:0]   w_wdist, p_wdist;
    logic [5:0]    w_wqual;
    logic [AW-1:0] rd_addr;
    logic [15:0]   wdist_rd, pdist_rd;
    logic [5:0]    wqual_rd;
    logic          scan_valid_reg, scan_valid_next;
    logic          scan_in_reg, scan_in_next;

    // Zone bounds reduced below 360
    logic [8:0] zs_red, ze_red, scan_idx;
    logic       in_zone;

    // Node degree reduced to a bucket index
    logic [8:0]    node_deg;
    logic [27:0]   deg_prod;
    logic [9:0]    deg_quot;
    logic [18:0]   deg_back;
    logic [18:0]   deg_rem;
    logic [AW-1:0] node_bucket;

    lsb_parser #(.HEADER_BYTES(HEADER_BYTES)) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .data_byte  (byte_reg),
        .result     (pres)
    );

    // Config port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MIN_QUALITY) ? {26'd0, minq_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            minq_reg <= MIN_QUALITY_RESET;
        else if (psel && penable && pwrite && paddr == ADDR_MIN_QUALITY)
            minq_reg <= pwdata[5:0];
    end

    // Capture accepted item
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            mode_reg <= mode;
            byte_reg <= data_byte;
            zs_reg   <= zone_start;
            ze_reg   <= zone_end;
            lim_reg  <= max_distance;
        end
    end

    assign zs_red = (zs_reg >= DEGREES) ? zs_reg - DEGREES : zs_reg;
    assign ze_red = (ze_reg >= DEGREES) ? ze_reg - DEGREES : ze_reg;
    assign scan_idx = (state_reg == ST_QUERY_LAST) ? 9'(addr_reg) : 9'(addr_reg) - 9'd1;

    // Shared compare unit: zone test of the bucket read last cycle
    always_comb
    begin
        if (zs_red <= ze_red)
            in_zone = (scan_idx >= zs_red) && (scan_idx <= ze_red);
        else
            in_zone = (scan_idx >= zs_red) || (scan_idx <= ze_red);
    end

    // Bucket of the node: degree minus quotient times BUCKETS
    assign node_deg    = pres.angle_word[14:6];
    assign deg_prod    = 28'(node_deg) * 28'(BUCKET_RECIP);
    assign deg_quot    = deg_prod[27:18];
    assign deg_back    = 19'(deg_quot) * 19'(BUCKETS);
    assign deg_rem     = 19'(node_deg) - deg_back;
    assign node_bucket = deg_rem[AW-1:0];

    assign busy = (state_reg != ST_IDLE);
    assign byte_valid = (state_reg == ST_DONE) && (mode_reg == MODE_BYTE) && !scan_valid_reg;

    // Sequencer
    always_comb
    begin
        logic [15:0] d;
        d = pdist_rd;
        state_next  = state_reg;
        addr_next   = addr_reg;
        sweeps_next = sweeps_reg;
        errors_next = errors_reg;
        armed_next  = armed_reg;
        done_next   = done_reg;
        err_next    = err_reg;
        obst_next   = obst_reg;
        found_next  = found_reg;
        near_next   = near_reg;
        store_next  = store_reg;
        bucket_next = bucket_reg;
        ndist_next  = ndist_reg;
        nqual_next  = nqual_reg;
        scan_valid_next = 1'b0;
        scan_in_next = 1'b0;
        rd_addr = addr_reg;
        w_we = 1'b0; w_waddr = addr_reg; w_wdist = '0; w_wqual = '0;
        p_we = 1'b0; p_waddr = addr_reg; p_wdist = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                w_we = 1'b1; p_we = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST)
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    done_next = 1'b0; err_next = 1'b0; obst_next = 1'b0;
                    found_next = 1'b0; near_next = '0; addr_next = '0;
                    state_next = (mode == MODE_QUERY) ? ST_QUERY : ST_DONE;
                    scan_valid_next = 1'b0;
                    if (mode == MODE_BYTE)
                        scan_valid_next = 1'b0;
                end
            end
            ST_DONE:
            begin
                // Parse the byte, or finish the item
                if ((mode_reg == MODE_QUERY) || scan_valid_reg)
                    state_next = ST_IDLE;
                else if (pres.header_error || pres.check_error)
                begin
                    err_next    = 1'b1;
                    errors_next = errors_reg + 1'b1;
                    scan_valid_next = 1'b1;
                end
                else if (pres.commit)
                begin
                    store_next  = (pres.quality >= minq_reg) && (pres.distance != 16'd0);
                    bucket_next = node_bucket;
                    ndist_next  = pres.distance;
                    nqual_next  = pres.quality;
                    addr_next   = '0;
                    armed_next  = 1'b1;
                    if (pres.sync && armed_reg)
                    begin
                        done_next   = 1'b1;
                        sweeps_next = sweeps_reg + 1'b1;
                        state_next  = ST_PUBLISH;
                    end
                    else
                        state_next = ST_COMMIT_RD;
                end
                else
                    scan_valid_next = 1'b1;
            end
            ST_PUBLISH:
            begin
                // Copy one bucket a cycle and clear the working sweep
                rd_addr = addr_reg;
                scan_valid_next = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (scan_valid_reg)
                begin
                    p_we = 1'b1; p_waddr = addr_reg - 1'b1; p_wdist = wdist_rd;
                    w_we = 1'b1; w_waddr = addr_reg - 1'b1;
                end
                if (scan_in_reg)
                begin
                    p_we = 1'b1; p_waddr = LAST; p_wdist = wdist_rd;
                    w_we = 1'b1; w_waddr = LAST;
                    addr_next = '0;
                    scan_valid_next = 1'b0;
                    state_next = ST_COMMIT_RD;
                end
                else if (addr_reg == LAST)
                begin
                    scan_in_next = 1'b1;
                    addr_next = addr_reg;
                end
            end
            ST_COMMIT_RD:
            begin
                rd_addr = bucket_reg;
                if (store_reg)
                    state_next = ST_COMMIT_WR;
                else
                begin
                    scan_valid_next = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_COMMIT_WR:
            begin
                // Keep the better quality entry
                if (wqual_rd < nqual_reg || wdist_rd == 16'd0)
                begin
                    w_we = 1'b1; w_waddr = bucket_reg;
                    w_wdist = ndist_reg; w_wqual = nqual_reg;
                end
                scan_valid_next = 1'b1;
                state_next = ST_DONE;
            end
            ST_QUERY:
            begin
                // Walk buckets one a cycle through the compare unit
                rd_addr = addr_reg;
                addr_next = addr_reg + 1'b1;
                scan_valid_next = 1'b1;
                if (scan_valid_reg && in_zone && d != 16'd0)
                begin
                    if (d <= lim_reg) obst_next = 1'b1;
                    if (!found_reg || d < near_reg) near_next = d;
                    found_next = 1'b1;
                end
                if (addr_reg == LAST)
                begin
                    addr_next = addr_reg;
                    state_next = ST_QUERY_LAST;
                end
            end
            ST_QUERY_LAST:
            begin
                if (in_zone && d != 16'd0)
                begin
                    if (d <= lim_reg) obst_next = 1'b1;
                    if (!found_reg || d < near_reg) near_next = d;
                    found_next = 1'b1;
                end
                state_next = ST_DONE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Result strobe: last cycle of every item
    assign result_valid     = (state_reg == ST_DONE) && ((mode_reg == MODE_QUERY) || scan_valid_reg);
    assign sweep_done       = done_reg;
    assign node_error       = err_reg;
    assign sweep_count      = sweeps_reg;
    assign error_count      = errors_reg;
    assign obstacle_found   = obst_reg;
    assign nearest_found    = found_reg;
    assign nearest_distance = near_reg;

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            addr_reg  <= '0;
            sweeps_reg <= '0;
            errors_reg <= '0;
            armed_reg <= 1'b0;
            done_reg <= 1'b0; err_reg <= 1'b0; obst_reg <= 1'b0;
            found_reg <= 1'b0;
            scan_valid_reg <= 1'b0;
            scan_in_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            sweeps_reg <= sweeps_next;
            errors_reg <= errors_next;
            armed_reg  <= armed_next;
            done_reg <= done_next; err_reg <= err_next; obst_reg <= obst_next;
            found_reg <= found_next;
            scan_valid_reg <= scan_valid_next;
            scan_in_reg <= scan_in_next;
        end
    end

    always_ff @(posedge clk)
    begin
        near_reg   <= near_next;
        store_reg  <= store_next;
        bucket_reg <= bucket_next;
        ndist_reg  <= ndist_next;
        nqual_reg  <= nqual_next;
    end

    // Bucket memories
    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            wdist_mem[w_waddr] <= w_wdist;
            wqual_mem[w_waddr] <= w_wqual;
        end
        if (p_we)
            pdist_mem[p_waddr] <= p_wdist;
        wdist_rd <= wdist_mem[rd_addr];
        wqual_rd <= wqual_mem[rd_addr];
        pdist_rd <= pdist_mem[rd_addr];
    end

    // Assertions
    a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !busy)
        else $error("result not followed by idle");
    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (mode_reg == MODE_QUERY) |-> !sweep_done && !node_error)
        else $error("query result carries stream flags");
    a_err_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && node_error |-> error_count == $past(error_count) + 32'd1
        || error_count != $past(error_count))
        else $error("error count not advanced");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> busy)
        else $error("result while idle");

endmodule

// ===== sim/lidar_scan_binner_checker.sv =====
// Checker for the scan binner: tracks parser and buckets, compares each result.
`timescale 1ns / 1ps
module lidar_scan_binner_checker
    import lsb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        start,
    input  logic        busy,
    input  logic        mode,
    input  logic [7:0]  data_byte,
    input  logic [8:0]  zone_start,
    input  logic [8:0]  zone_end,
    input  logic [15:0] max_distance,
    input  logic        result_valid,
    input  logic        sweep_done,
    input  logic        node_error,
    input  logic [31:0] sweep_count,
    input  logic [31:0] error_count,
    input  logic        obstacle_found,
    input  logic        nearest_found,
    input  logic [15:0] nearest_distance,
    output int          fail_count,
    output int          pending
);

    localparam int NBUCKETS = 360;
    localparam int NHDR     = 5;

    typedef struct packed {
        logic        sweep_done;
        logic        node_error;
        logic [31:0] sweep_count;
        logic [31:0] error_count;
        logic        obstacle_found;
        logic        nearest_found;
        logic [15:0] nearest_distance;
    } scan_result_t;

    scan_result_t expected_results[$];

    // Shadow of the block state
    logic [5:0]  min_q;
    phase_t      phase;
    int          hdr_pos;
    int          node_pos;
    logic [7:0]  node_buf [4];
    logic        armed;
    logic [15:0] work_dist [NBUCKETS];
    logic [5:0]  work_qual [NBUCKETS];
    logic [15:0] pub_dist  [NBUCKETS];
    logic [31:0] sweeps;
    logic [31:0] errors;

    assign pending = expected_results.size();

    // Decode a finished node: publish the sweep on a sync, then bin it into the working sweep
    task automatic commit_node(input logic [7:0] last, output logic done, output logic err);
        logic [15:0] aw;
        logic [15:0] dw;
        logic [5:0]  q;
        int          b;
        aw = {node_buf[2], node_buf[1]};
        dw = {last, node_buf[3]};
        q = node_buf[0][7:2];
        done = 1'b0;
        err = 1'b0;
        if (!aw[0]) begin
            errors++;
            err = 1'b1;
            return;
        end
        if (node_buf[0][0] && armed) begin
            for (int i = 0; i < NBUCKETS; i++) begin
                pub_dist[i] = work_dist[i];
                work_dist[i] = '0;
                work_qual[i] = '0;
            end
            sweeps++;
            done = 1'b1;
        end
        armed = 1'b1;
        if (q < min_q || dw == 16'd0)
            return;
        b = (int'(aw[15:1]) / 64) % NBUCKETS;
        if (work_qual[b] < q || work_dist[b] == 16'd0) begin
            work_dist[b] = dw;
            work_qual[b] = q;
        end
    endtask

    // Work out the result of one accepted item
    task automatic predict_scan_result(output scan_result_t r);
        int s;
        int e;
        logic hit;
        logic d;
        logic er;
        r = '0;
        if (mode == MODE_BYTE) begin
            d = 1'b0;
            er = 1'b0;
            case (phase)
                PH_SYNC1:
                    if (data_byte == SYNC1_BYTE)
                        phase = PH_SYNC2;
                PH_SYNC2:
                    if (data_byte == SYNC2_BYTE) begin
                        hdr_pos = 0;
                        phase = PH_HEADER;
                    end
                    else if (data_byte != SYNC1_BYTE)
                        phase = PH_SYNC1;
                PH_HEADER:
                begin
                    hdr_pos++;
                    if (hdr_pos >= NHDR) begin
                        hdr_pos = 0;
                        if (data_byte == HEADER_TYPE) begin
                            node_pos = 0;
                            phase = PH_NODES;
                        end
                        else begin
                            errors++;
                            er = 1'b1;
                            phase = PH_SYNC1;
                        end
                    end
                end
                default:
                    if (node_pos >= 4) begin
                        node_pos = 0;
                        commit_node(data_byte, d, er);
                    end
                    else begin
                        node_buf[node_pos] = data_byte;
                        node_pos++;
                    end
            endcase
            r.sweep_done = d;
            r.node_error = er;
        end
        else begin
            s = zone_start;
            e = zone_end;
            if (s >= NBUCKETS) s -= NBUCKETS;
            if (e >= NBUCKETS) e -= NBUCKETS;
            for (int i = 0; i < NBUCKETS; i++) begin
                hit = (s <= e) ? (i >= s && i <= e) : (i >= s || i <= e);
                if (pub_dist[i] != 16'd0 && hit) begin
                    if (pub_dist[i] <= max_distance)
                        r.obstacle_found = 1'b1;
                    if (!r.nearest_found || pub_dist[i] < r.nearest_distance)
                        r.nearest_distance = pub_dist[i];
                    r.nearest_found = 1'b1;
                end
            end
        end
        r.sweep_count = sweeps;
        r.error_count = errors;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        scan_result_t exp_r;
        scan_result_t got;
        if (!rst_n) begin
            min_q = MIN_QUALITY_RESET;
            phase = PH_SYNC1;
            hdr_pos = 0;
            node_pos = 0;
            armed = 1'b0;
            sweeps = '0;
            errors = '0;
            fail_count <= 0;
            for (int i = 0; i < NBUCKETS; i++) begin
                work_dist[i] = '0;
                work_qual[i] = '0;
                pub_dist[i] = '0;
            end
            for (int i = 0; i < 4; i++)
                node_buf[i] = '0;
        end
        else begin
            // Compare the result item against the oldest expectation
            if (result_valid) begin
                got = '{sweep_done, node_error, sweep_count, error_count,
                        obstacle_found, nearest_found, nearest_distance};
                if (expected_results.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("ERROR: unexpected result %p", got);
                end
                else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("ERROR: result mismatch expected %p actual %p",
                                     exp_r, got);
                    end
                end
            end
            // Track register writes
            if (psel && penable && pwrite && pready && paddr == ADDR_MIN_QUALITY)
                min_q = pwdata[5:0];
            // Predict the accepted item
            if (start && !busy) begin
                predict_scan_result(exp_r);
                expected_results.push_back(exp_r);
            end
        end
    end

endmodule

// ===== sim/lidar_scan_binner_tb.sv =====
// Testbench top for the scan binner: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module lidar_scan_binner_tb;
    import lsb_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic        start, busy;
    logic        mode;
    logic [7:0]  data_byte;
    logic [8:0]  zone_start, zone_end;
    logic [15:0] max_distance;
    logic        result_valid, sweep_done, node_error;
    logic [31:0] sweep_count, error_count;
    logic        obstacle_found, nearest_found;
    logic [15:0] nearest_distance;
    int          fail_count, pending;
    int          items_sent;
    int          idle_cycles;
    bit          idle_on;

    lidar_scan_binner DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .mode(mode), .data_byte(data_byte),
        .zone_start(zone_start), .zone_end(zone_end), .max_distance(max_distance),
        .result_valid(result_valid), .sweep_done(sweep_done), .node_error(node_error),
        .sweep_count(sweep_count), .error_count(error_count),
        .obstacle_found(obstacle_found), .nearest_found(nearest_found),
        .nearest_distance(nearest_distance)
    );

    lidar_scan_binner_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .start(start), .busy(busy), .mode(mode), .data_byte(data_byte),
        .zone_start(zone_start), .zone_end(zone_end), .max_distance(max_distance),
        .result_valid(result_valid), .sweep_done(sweep_done), .node_error(node_error),
        .sweep_count(sweep_count), .error_count(error_count),
        .obstacle_found(obstacle_found), .nearest_found(nearest_found),
        .nearest_distance(nearest_distance),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Hand one item to the block and hold it until accepted
    task automatic send_item(input logic m, input logic [7:0] b, input logic [8:0] zs,
                             input logic [8:0] ze, input logic [15:0] md);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        mode <= m;
        data_byte <= b;
        zone_start <= zs;
        zone_end <= ze;
        max_distance <= md;
        @(posedge clk);
        while (busy) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(MODE_BYTE, b, 9'($urandom), 9'($urandom), 16'($urandom));
    endtask

    task automatic send_query(input logic [8:0] zs, input logic [8:0] ze,
                              input logic [15:0] md);
        send_item(MODE_QUERY, 8'($urandom), zs, ze, md);
    endtask

    task automatic send_header(input logic [7:0] htype);
        send_byte(SYNC1_BYTE);
        send_byte(SYNC2_BYTE);
        repeat (4) send_byte(8'($urandom));
        send_byte(htype);
    endtask

    task automatic send_node(input logic sync, input logic [5:0] q, input logic chk,
                             input logic [14:0] ang, input logic [15:0] node_dist);
        send_byte({q, 1'($urandom), sync});
        send_byte({ang[6:0], chk});
        send_byte(ang[14:7]);
        send_byte(node_dist[7:0]);
        send_byte(node_dist[15:8]);
    endtask

    task automatic send_random_node();
        logic [15:0] node_dist;
        case ($urandom_range(0, 7))
            0: node_dist = 16'd0;
            1: node_dist = 16'($urandom_range(1, 300));
            default: node_dist = 16'($urandom);
        endcase
        send_node($urandom_range(0, 11) == 0, 6'($urandom), $urandom_range(0, 9) != 0,
                  15'($urandom), node_dist);
    endtask

    task automatic send_random_query();
        send_query(9'($urandom), 9'($urandom),
                   ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'($urandom_range(0, 4000)));
    endtask

    // Quiesce, then write min_quality
    task automatic write_min_quality(input logic [5:0] value);
        start <= 1'b0;
        @(posedge clk);
        while (busy || pending != 0) @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_MIN_QUALITY;
        pwdata <= {26'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    send_header(HEADER_TYPE);
                    repeat ($urandom_range(1, 10)) send_random_node();
                    if ($urandom_range(0, 2) == 0) send_byte(8'($urandom));
                end
                6, 7: send_random_query();
                8: repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
                default:
                begin
                    send_header(($urandom_range(0, 1) == 1) ? 8'($urandom) : HEADER_TYPE);
                    repeat ($urandom_range(0, 7)) send_byte(8'($urandom));
                end
            endcase
        end
    endtask

    initial
    begin
        int wait_cycles;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        mode = 1'b0;
        data_byte = '0;
        zone_start = '0;
        zone_end = '0;
        max_distance = '0;
        items_sent = 0;
        idle_on = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty query, sync handling, header and node special cases
        send_query(9'd0, 9'd359, 16'hFFFF);
        send_byte(8'h00);
        send_byte(SYNC1_BYTE);
        send_byte(SYNC1_BYTE);
        send_byte(8'h13);
        send_header(8'h80);
        send_header(HEADER_TYPE);
        send_node(1'b1, 6'd63, 1'b1, 15'd0, 16'd400);
        send_node(1'b0, 6'd20, 1'b0, 15'h7FFF, 16'hFFFF);
        send_node(1'b0, 6'd9, 1'b1, 15'd64 * 15'd10, 16'd100);
        send_node(1'b0, 6'd30, 1'b1, 15'h7FFF, 16'd0);
        send_node(1'b0, 6'd40, 1'b1, 15'h7FFF, 16'hFFFF);
        send_node(1'b0, 6'd10, 1'b1, 15'd64 * 15'd359 + 15'd63, 16'd1);
        send_node(1'b1, 6'd0, 1'b1, 15'd64 * 15'd200, 16'd500);
        send_query(9'd350, 9'd10, 16'd0);
        send_query(9'd511, 9'd400, 16'd1);
        send_query(9'd359, 9'd359, 16'hFFFF);
        send_query(9'd100, 9'd99, 16'd400);

        write_min_quality(6'd0);
        random_phase(180);
        write_min_quality(6'd63);
        random_phase(150);
        write_min_quality(6'($urandom_range(1, 62)));
        random_phase(180);
        write_min_quality(MIN_QUALITY_RESET);
        idle_on = 1'b0;
        random_phase(180);
        start <= 1'b0;

        // Drain outstanding results
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 2000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (400) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
